// ===== hdl/srrw_pkg.sv =====
package srrw_pkg;

    localparam int MAX_WINDOW    = 8;
    localparam int MAX_SEQ_RANGE = 32;

    // field and register widths fixed by the interface
    localparam int SEQ_W       = 5;
    localparam int CFG_WIN_W   = 4;
    localparam int CFG_RANGE_W = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 2;

    localparam int SLOT_W = $clog2(MAX_WINDOW);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_RANGE   = CFG_IDX_W'(1);

    localparam logic [CFG_WIN_W-1:0]   WINDOW_RESET = CFG_WIN_W'(7);
    localparam logic [CFG_RANGE_W-1:0] RANGE_RESET  = CFG_RANGE_W'(17);

    // result of the window check for one arriving sequence number
    typedef struct packed {
        logic                   hit;
        logic                   at_base;
        logic [SLOT_W-1:0]      slot;
        logic [CFG_RANGE_W-1:0] range;
        logic [CFG_WIN_W-1:0]   win;
    } srrw_check_t;

endpackage

// ===== hdl/srrw_window_check.sv =====
module srrw_window_check (
    input  logic [srrw_pkg::CFG_WIN_W-1:0]   window_size,
    input  logic [srrw_pkg::CFG_RANGE_W-1:0] seq_range,
    input  logic [srrw_pkg::SEQ_W-1:0]       seq_num,
    input  logic [srrw_pkg::SEQ_W-1:0]       base,
    input  logic [srrw_pkg::SLOT_W-1:0]      head,
    output srrw_pkg::srrw_check_t            check
);
    import srrw_pkg::*;

    logic [CFG_RANGE_W-1:0] rng;
    logic [CFG_WIN_W-1:0]   win;
    logic [CFG_RANGE_W-1:0] seq_ext;
    logic [CFG_RANGE_W-1:0] base_ext;
    logic [CFG_RANGE_W-1:0] delta;

    always_comb begin
        priority if (seq_range < CFG_RANGE_W'(2)) begin
            rng = CFG_RANGE_W'(2);
        end else if (seq_range > CFG_RANGE_W'(MAX_SEQ_RANGE)) begin
            rng = CFG_RANGE_W'(MAX_SEQ_RANGE);
        end else begin
            rng = seq_range;
        end
    end

    // clamp to [1, MAX_WINDOW], then below the range
    always_comb begin
        priority if (window_size == '0) begin
            win = CFG_WIN_W'(1);
        end else if (window_size > CFG_WIN_W'(MAX_WINDOW)) begin
            win = CFG_WIN_W'(MAX_WINDOW);
        end else begin
            win = window_size;
        end
        if ({{(CFG_RANGE_W-CFG_WIN_W){1'b0}}, win} > rng - CFG_RANGE_W'(1)) begin
            win = CFG_WIN_W'(rng - CFG_RANGE_W'(1));
        end
    end

    assign seq_ext  = CFG_RANGE_W'(seq_num);
    assign base_ext = CFG_RANGE_W'(base);

    // circular distance from the base, wrapping modulo the range
    always_comb begin
        if (seq_ext >= base_ext) begin
            delta = seq_ext - base_ext;
        end else begin
            delta = seq_ext - base_ext + rng;
        end
    end

    assign check.hit     = (seq_ext < rng) &&
                           (delta < {{(CFG_RANGE_W-CFG_WIN_W){1'b0}}, win});
    assign check.at_base = (delta == '0);
    assign check.slot    = head + delta[SLOT_W-1:0];
    assign check.range   = rng;
    assign check.win     = win;

endmodule

// ===== hdl/selective_repeat_receive_window.sv =====
// Selective-repeat receive window.
// Input channel s_valid/s_ready carries one arriving sequence number per word.
// A number inside the circular window [base, base+W-1] (mod range) marks its
// slot in an 8-entry ring of received flags. A number equal to the base also
// releases the run of consecutive received numbers on m_valid/m_ready, in
// order, one word per cycle, with m_last_of_run high on the final word.
// Other numbers, and numbers at or above the range, produce no output.
// Drain: an arrival at the base starts the drain sequencer, which releases
// the run of 1 to W numbers (W at most 8); no new item is taken until the
// run is done. The drain walks the ring with a single base incrementer and
// compare that wraps modulo the range.
// s_ready is low while a run is draining. A stall on m_ready holds the output
// register and pauses the drain; nothing is dropped.
// Writes on cfg_wr_en (index 0 window size, 1 sequence range) take effect at
// once and also clear base, head slot and all flags; other indexes are ignored.
// Reset (aresetn low, synchronous) loads window 7, range 17, base 0, head slot
// 0, all flags clear, and empties the output register.
module selective_repeat_receive_window (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [srrw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [srrw_pkg::SEQ_W-1:0]       s_seq_num,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [srrw_pkg::SEQ_W-1:0]       m_delivered_seq,
    output logic                             m_last_of_run
);
    import srrw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                  state_reg;
    logic [CFG_WIN_W-1:0]    window_size_reg;
    logic [CFG_RANGE_W-1:0]  seq_range_reg;
    logic [SEQ_W-1:0]        base_reg;
    logic [SLOT_W-1:0]       head_reg;
    logic [MAX_WINDOW-1:0]   flags_reg;
    logic [CFG_WIN_W-1:0]    cnt_reg;
    logic                    m_valid_reg;
    logic [SEQ_W-1:0]        m_seq_reg;
    logic                    m_last_reg;

    srrw_check_t             check;
    logic                    out_free;
    logic                    drain_step;
    logic                    m_valid_next;
    logic [SLOT_W-1:0]       head_next;
    logic [CFG_RANGE_W-1:0]  base_inc;
    logic [SEQ_W-1:0]        base_next;
    logic [CFG_WIN_W-1:0]    cnt_next;
    logic                    run_last;

    srrw_window_check u_check (
        .window_size (window_size_reg),
        .seq_range   (seq_range_reg),
        .seq_num     (s_seq_num),
        .base        (base_reg),
        .head        (head_reg),
        .check       (check)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_delivered_seq = m_seq_reg;
    assign m_last_of_run   = m_last_reg;

    assign out_free     = !m_valid_reg || m_ready;
    assign drain_step   = (state_reg == ST_DRAIN) && out_free;
    assign m_valid_next = drain_step || (m_valid_reg && !m_ready);
    assign head_next    = head_reg + SLOT_W'(1);
    assign base_inc     = CFG_RANGE_W'(base_reg) + CFG_RANGE_W'(1);
    assign base_next    = (base_inc == check.range) ? '0 : base_inc[SEQ_W-1:0];
    assign cnt_next     = cnt_reg + CFG_WIN_W'(1);
    // run ends at the window length or at the first gap
    assign run_last     = (cnt_next == check.win) || !flags_reg[head_next];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_RESET;
            seq_range_reg   <= RANGE_RESET;
            base_reg        <= '0;
            head_reg        <= '0;
            flags_reg       <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && check.hit) begin
                        flags_reg[check.slot] <= 1'b1;
                        if (check.at_base) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        m_seq_reg           <= base_reg;
                        m_last_reg          <= run_last;
                        flags_reg[head_reg] <= 1'b0;
                        base_reg            <= base_next;
                        head_reg            <= head_next;
                        cnt_reg             <= cnt_next;
                        if (run_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_wr_en) begin
                if (cfg_index == REG_WINDOW_SIZE) begin
                    window_size_reg <= cfg_wr_data[CFG_WIN_W-1:0];
                    base_reg        <= '0;
                    head_reg        <= '0;
                    flags_reg       <= '0;
                end else if (cfg_index == REG_SEQ_RANGE) begin
                    seq_range_reg <= cfg_wr_data[CFG_RANGE_W-1:0];
                    base_reg      <= '0;
                    head_reg      <= '0;
                    flags_reg     <= '0;
                end
            end
        end
    end

endmodule
